/* rtl/midpoint_circle_rasterizer_assert.svh */
// Assertion macros shared by the circle rasteriser modules.
// Each macro expands to one labelled concurrent assertion; no other dependencies.
`ifndef MIDPOINT_CIRCLE_RASTERIZER_ASSERT_SVH
`define MIDPOINT_CIRCLE_RASTERIZER_ASSERT_SVH

// Same-cycle implication, switched off while reset is high.
`define MCR_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: implication check failed");

// Next-cycle implication, switched off while reset is high.
`define MCR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: next-cycle check failed");

`endif

/* rtl/mcr_pkg.sv */
// Shared widths, register codes and the step record type of the circle rasteriser.
// No dependencies; imported by every module of the block.
package mcr_pkg;

   localparam int RADIUS_BITS = 12;
   localparam int CENTER_W    = 16;
   localparam int POINT_W     = 17;
   localparam int X_W         = RADIUS_BITS + 2;   // signed, holds radius-1 down to -1
   localparam int Y_W         = RADIUS_BITS + 1;   // unsigned
   localparam int T_W         = RADIUS_BITS + 2;   // unsigned odd increments
   // Signed decision term. A radius cut while a circle is open lets the x update add
   // the growing increment on every step, so the term can reach about radius squared.
   localparam int E_W         = 2 * RADIUS_BITS + 3;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam int OCT_W = 3;
   localparam logic [OCT_W-1:0] OCT_LAST = 3'd7;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_CENTER_X = 2'd0,
      CSR_CENTER_Y = 2'd1,
      CSR_RADIUS   = 2'd2
   } csr_index_type;

   // One step of the outline: the offsets to mirror and whether it ends the circle.
   typedef struct packed {
      logic signed [X_W-1:0] x;
      logic [Y_W-1:0]        y;
      logic                  last;
   } step_rec_type;

endpackage

/* rtl/midpoint_circle_rasterizer.sv */
// Top level of the midpoint circle outline rasteriser.
// Depends on mcr_pkg, mcr_front, mcr_queue and mcr_back.
//
//   Channel   Handshake       Payload
//   request   push / full     req_restart
//   response  pop / empty     rsp_point_x, rsp_point_y, rsp_octant,
//                             rsp_last_in_step, rsp_last_of_circle
//   csr       csr_we          csr_index, csr_wdata
//
// A step that draws yields eight points on the response side, one point per cycle while pop keeps up.
// A request that draws nothing completes in the cycle of its transfer.
// The front end computes a step in the cycle of its request transfer; up to two steps wait in the queue.
// full rises only while that queue holds two steps; a stalled pop never loses a point.
// Reset is synchronous; there is no clearing pass.
module midpoint_circle_rasterizer (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 push,
   output logic                                 full,
   input  logic                                 req_restart,
   output logic                                 empty,
   input  logic                                 pop,
   output logic signed [mcr_pkg::POINT_W-1:0]   rsp_point_x,
   output logic signed [mcr_pkg::POINT_W-1:0]   rsp_point_y,
   output logic [mcr_pkg::OCT_W-1:0]            rsp_octant,
   output logic                                 rsp_last_in_step,
   output logic                                 rsp_last_of_circle,
   input  logic                                 csr_we,
   input  logic [mcr_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [mcr_pkg::CSR_DATA_W-1:0]       csr_wdata
);
   import mcr_pkg::*;

   logic signed [CENTER_W-1:0] center_x_ff, center_x_in;
   logic signed [CENTER_W-1:0] center_y_ff, center_y_in;
   logic [RADIUS_BITS-1:0]     radius_ff, radius_in;

   step_rec_type rec_data, head_data;
   logic         rec_push, queue_full, queue_empty, queue_pop;

   // Writes to an index beyond the register list are dropped.
   always_comb begin
      center_x_in = center_x_ff;
      center_y_in = center_y_ff;
      radius_in   = radius_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_CENTER_X: center_x_in = signed'(csr_wdata[CENTER_W-1:0]);
            CSR_CENTER_Y: center_y_in = signed'(csr_wdata[CENTER_W-1:0]);
            CSR_RADIUS:   radius_in   = csr_wdata[RADIUS_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff <= '0;
         center_y_ff <= '0;
         radius_ff   <= '0;
      end else begin
         center_x_ff <= center_x_in;
         center_y_ff <= center_y_in;
         radius_ff   <= radius_in;
      end
   end

   // Full reflects only the queue, so a request transfer is possible every cycle that the queue is not
   // full, also while the back end is still busy with earlier steps.
   assign full = queue_full;

   mcr_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_push    (push),
      .req_restart (req_restart),
      .queue_full  (queue_full),
      .radius      (radius_ff),
      .rec_push    (rec_push),
      .rec_data    (rec_data)
   );

   mcr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_i    (rec_push),
      .push_data (rec_data),
      .pop_i     (queue_pop),
      .head_data (head_data),
      .full_o    (queue_full),
      .empty_o   (queue_empty)
   );

   mcr_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head_data      (head_data),
      .queue_empty    (queue_empty),
      .queue_pop      (queue_pop),
      .center_x       (center_x_ff),
      .center_y       (center_y_ff),
      .empty          (empty),
      .pop            (pop),
      .point_x        (rsp_point_x),
      .point_y        (rsp_point_y),
      .octant         (rsp_octant),
      .last_in_step   (rsp_last_in_step),
      .last_of_circle (rsp_last_of_circle)
   );

endmodule

/* rtl/mcr_front.sv */
// Front end: accepts step requests and advances the midpoint circle state.
// Depends on mcr_pkg; feeds step records to mcr_queue.
module mcr_front (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_push,
   input  logic                             req_restart,
   input  logic                             queue_full,
   input  logic [mcr_pkg::RADIUS_BITS-1:0]  radius,
   output logic                             rec_push,
   output mcr_pkg::step_rec_type            rec_data
);
   import mcr_pkg::*;

   logic signed [X_W-1:0] x_ff, x_in, x_s, x_1, x_2;
   logic [Y_W-1:0]        y_ff, y_in, y_s, y_1, y_2;
   logic [T_W-1:0]        tx_ff, tx_in, tx_s, tx_1, tx_2;
   logic [T_W-1:0]        ty_ff, ty_in, ty_s, ty_1;
   logic signed [E_W-1:0] err_ff, err_in, err_s, err_1, err_2, diam;
   logic                  active_ff, active_in, act_s;
   logic                  accept, emit, done;

   assign accept = req_push && !queue_full;
   assign diam   = signed'({{(E_W-RADIUS_BITS-1){1'b0}}, radius, 1'b0});

   always_comb begin
      // A restart loads a fresh circle, then the same item takes its first step.
      if (req_restart) begin
         x_s   = signed'(X_W'(radius)) - X_W'(1);
         y_s   = '0;
         tx_s  = T_W'(1);
         ty_s  = T_W'(1);
         err_s = E_W'(1) - diam;
         act_s = (radius != '0);
      end else begin
         x_s   = x_ff;
         y_s   = y_ff;
         tx_s  = tx_ff;
         ty_s  = ty_ff;
         err_s = err_ff;
         act_s = active_ff;
      end
      emit = act_s && !(x_s < signed'({1'b0, y_s}));

      // y update first, then the x update sees the new error term.
      if (err_s <= 0) begin
         y_1   = y_s + Y_W'(1);
         err_1 = err_s + signed'({{(E_W-T_W){1'b0}}, ty_s});
         ty_1  = ty_s + T_W'(2);
      end else begin
         y_1   = y_s;
         err_1 = err_s;
         ty_1  = ty_s;
      end
      y_2 = y_1;
      if (err_1 > 0) begin
         x_2   = x_s - X_W'(1);
         tx_2  = tx_s + T_W'(2);
         err_2 = err_1 + signed'({{(E_W-T_W){1'b0}}, tx_2}) - diam;
      end else begin
         x_2   = x_s;
         tx_2  = tx_s;
         err_2 = err_1;
      end
      done = (x_2 < signed'({1'b0, y_2}));
      x_1  = x_2;
      tx_1 = tx_2;

      x_in      = x_ff;
      y_in      = y_ff;
      tx_in     = tx_ff;
      ty_in     = ty_ff;
      err_in    = err_ff;
      active_in = active_ff;
      if (accept) begin
         if (emit) begin
            x_in      = x_1;
            y_in      = y_2;
            tx_in     = tx_1;
            ty_in     = ty_1;
            err_in    = err_2;
            active_in = !done;
         end else begin
            x_in      = x_s;
            y_in      = y_s;
            tx_in     = tx_s;
            ty_in     = ty_s;
            err_in    = err_s;
            active_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_ff      <= '0;
         y_ff      <= '0;
         tx_ff     <= T_W'(1);
         ty_ff     <= T_W'(1);
         err_ff    <= '0;
         active_ff <= 1'b0;
      end else begin
         x_ff      <= x_in;
         y_ff      <= y_in;
         tx_ff     <= tx_in;
         ty_ff     <= ty_in;
         err_ff    <= err_in;
         active_ff <= active_in;
      end
   end

   assign rec_push      = accept && emit;
   assign rec_data.x    = x_s;
   assign rec_data.y    = y_s;
   assign rec_data.last = done;

endmodule

/* rtl/mcr_queue.sv */
// Short queue of step records between the front and back ends.
// Depends on mcr_pkg and the assertion macro header.
module mcr_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push_i,
   input  mcr_pkg::step_rec_type push_data,
   input  logic                  pop_i,
   output mcr_pkg::step_rec_type head_data,
   output logic                  full_o,
   output logic                  empty_o
);
   import mcr_pkg::*;
   `include "midpoint_circle_rasterizer_assert.svh"

   step_rec_type        entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;

   assign full_o    = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign empty_o   = (count_ff == '0);
   assign head_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_i) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (pop_i) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      if (push_i && !pop_i) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop_i && !push_i) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_i) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   `MCR_ASSERT_IMPLIES(a_no_overflow, clock, reset, push_i, !full_o)
   `MCR_ASSERT_IMPLIES(a_no_underflow, clock, reset, pop_i, !empty_o)

endmodule

/* rtl/mcr_back.sv */
// Back end: mirrors each step record into eight points, one per cycle while pop does not stall.
// Depends on mcr_pkg and the assertion macro header; drains mcr_queue.
module mcr_back (
   input  logic                                 clock,
   input  logic                                 reset,
   input  mcr_pkg::step_rec_type                head_data,
   input  logic                                 queue_empty,
   output logic                                 queue_pop,
   input  logic signed [mcr_pkg::CENTER_W-1:0]  center_x,
   input  logic signed [mcr_pkg::CENTER_W-1:0]  center_y,
   output logic                                 empty,
   input  logic                                 pop,
   output logic signed [mcr_pkg::POINT_W-1:0]   point_x,
   output logic signed [mcr_pkg::POINT_W-1:0]   point_y,
   output logic [mcr_pkg::OCT_W-1:0]            octant,
   output logic                                 last_in_step,
   output logic                                 last_of_circle
);
   import mcr_pkg::*;
   `include "midpoint_circle_rasterizer_assert.svh"

   logic [OCT_W-1:0]          oct_ff, oct_in;
   logic                      valid_ff, valid_in;
   logic signed [POINT_W-1:0] px_ff, px_in, py_ff, py_in;
   logic [OCT_W-1:0]          ooct_ff;
   logic                      olast_ff, ocirc_ff;
   logic signed [POINT_W-1:0] cx, cy, ox, oy, a, b;
   logic                      load;

   assign load      = !queue_empty && (!valid_ff || pop);
   assign queue_pop = load && (oct_ff == OCT_LAST);

   always_comb begin
      cx = POINT_W'(center_x);
      cy = POINT_W'(center_y);
      ox = POINT_W'(head_data.x);
      oy = signed'({{(POINT_W-Y_W){1'b0}}, head_data.y});
      // Upper four points swap the roles of x and y.
      a  = oct_ff[2] ? oy : ox;
      b  = oct_ff[2] ? ox : oy;
      px_in = oct_ff[1] ? (cx - a) : (cx + a);
      py_in = oct_ff[0] ? (cy + b) : (cy - b);

      oct_in   = load ? oct_ff + OCT_W'(1) : oct_ff;
      valid_in = load || (valid_ff && !pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         oct_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         oct_ff   <= oct_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         px_ff    <= px_in;
         py_ff    <= py_in;
         ooct_ff  <= oct_ff;
         olast_ff <= (oct_ff == OCT_LAST);
         ocirc_ff <= (oct_ff == OCT_LAST) && head_data.last;
      end
   end

   assign empty          = !valid_ff;
   assign point_x        = px_ff;
   assign point_y        = py_ff;
   assign octant         = ooct_ff;
   assign last_in_step   = olast_ff;
   assign last_of_circle = ocirc_ff;

   `MCR_ASSERT_IMPLIES(a_circle_ends_step, clock, reset, valid_ff && ocirc_ff, olast_ff)
   `MCR_ASSERT_NEXT(a_points_follow, clock, reset, valid_ff && pop && !olast_ff, valid_ff && (ooct_ff == $past(ooct_ff) + 3'd1))

endmodule
